[design/joystick_polar_deadband_macros.svh]
// assertion macros for the joystick polar deadband block
`ifndef JOYSTICK_POLAR_DEADBAND_MACROS_SVH
`define JOYSTICK_POLAR_DEADBAND_MACROS_SVH

// implication checked every clock, off during reset
`define JPD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked on the next clock
`define JPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/jpd_pkg.sv]
// package: constants, stage type and stage logic for the joystick polar deadband pipeline
package jpd_pkg;

  localparam int ANGLE_FRAC_BITS = 6;
  localparam int CORDIC_STEPS = 16;
  localparam int DIV_STEPS = 16;
  localparam int SETUP_STAGE = CORDIC_STEPS + 1;
  localparam int NUM_STAGES = SETUP_STAGE + DIV_STEPS + 2;
  localparam int ROUND_SHIFT = 16 - ANGLE_FRAC_BITS;

  localparam logic [25:0] ROUND_HALF = 26'(1) << (ROUND_SHIFT - 1);
  localparam logic signed [24:0] DEG_90 = 25'sd5898240;
  localparam logic [24:0] DEG_90U = 25'd5898240;
  localparam logic [24:0] DEG_180 = 25'd11796480;
  localparam logic [24:0] DEG_270 = 25'd17694720;
  localparam logic [24:0] DEG_360 = 25'd23592960;
  localparam logic [15:0] DIV_ONE = 16'd32768;

  localparam logic signed [24:0] ATAN_TAB [CORDIC_STEPS] = '{
    25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
    25'sd234379, 25'sd117304, 25'sd58666, 25'sd29335,
    25'sd14668, 25'sd7334, 25'sd3667, 25'sd1833,
    25'sd917, 25'sd458, 25'sd229, 25'sd115
  };

  typedef struct packed {
    logic special;
    logic [24:0] sp_acc;
    logic upos;
    logic vpos;
    logic signed [21:0] x;
    logic signed [21:0] y;
    logic signed [24:0] z;
    logic [31:0] rem;
    logic [31:0] root;
    logic [14:0] ang;
    logic [15:0] dvs;
    logic [15:0] q;
    logic ovf;
    logic zero;
  } jpd_stage_t;

  // cordic iteration and square-root digit
  function automatic jpd_stage_t jpd_cordic_step(int i, jpd_stage_t p);
    jpd_stage_t r;
    logic [31:0] bitv;
    logic [31:0] trial;
    r = p;
    bitv = 32'(1) << (30 - 2 * i);
    trial = p.root + bitv;
    if (p.y >= 0) begin
      r.x = p.x + (p.y >>> i);
      r.y = p.y - (p.x >>> i);
      r.z = p.z + ATAN_TAB[i];
    end else begin
      r.x = p.x - (p.y >>> i);
      r.y = p.y + (p.x >>> i);
      r.z = p.z - ATAN_TAB[i];
    end
    if (p.rem >= trial) begin
      r.rem = p.rem - trial;
      r.root = (p.root >> 1) + bitv;
    end else begin
      r.root = p.root >> 1;
    end
    return r;
  endfunction

  // quadrant fold, angle rounding and divider set-up
  function automatic jpd_stage_t jpd_setup(jpd_stage_t p, logic [14:0] d);
    jpd_stage_t r;
    logic [24:0] t;
    logic [24:0] acc;
    logic [25:0] rnd;
    logic [15:0] m;
    logic [15:0] diff;
    r = p;
    if (p.z < 0) begin
      t = '0;
    end else if (p.z > DEG_90) begin
      t = DEG_90U;
    end else begin
      t = p.z[24:0];
    end
    if (p.special) begin
      acc = p.sp_acc;
    end else if (p.vpos) begin
      acc = p.upos ? DEG_180 + t : DEG_360 - t;
    end else begin
      acc = p.upos ? DEG_180 - t : t;
    end
    rnd = {1'b0, acc} + ROUND_HALF;
    r.ang = 15'(rnd >> ROUND_SHIFT);
    m = p.root[15:0];
    r.zero = (m <= {1'b0, d});
    diff = m - {1'b0, d};
    r.rem = {1'b0, diff, 15'b0};
    r.dvs = DIV_ONE - {1'b0, d};
    r.ovf = ({1'b0, r.rem} >= {1'b0, r.dvs, 16'b0});
    r.q = '0;
    return r;
  endfunction

  // one restoring division bit, k counts down from 15
  function automatic jpd_stage_t jpd_div_step(int k, jpd_stage_t p);
    jpd_stage_t r;
    logic [31:0] sub;
    r = p;
    sub = {16'b0, p.dvs} << k;
    if (p.rem >= sub) begin
      r.rem = p.rem - sub;
      r.q[k] = 1'b1;
    end
    return r;
  endfunction

endpackage

[design/joystick_polar_deadband.sv]
// joystick polar deadband: top level, cordic, square root and divider pipeline
// Usage: a request on raw_x/raw_y is taken when in_valid and in_ready are both
// high; the angle/magnitude result appears on out_valid and is taken when
// out_ready is high.
// The pipeline is 35 register stages long. Throughput is one request per
// cycle while the output is not stalled; the stage count is set by the 16
// cordic iterations (run alongside 16 square-root digits), one set-up stage,
// 16 division bits and the input and output registers.
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready falls; nothing is lost or repeated. While the last stage is empty the
// pipeline keeps moving regardless of out_ready.
// The deadband register is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this; it resets to zero.
// Reset (rst, synchronous) empties the pipeline and clears the deadband.
// Angle is in 1/64 degree; magnitude is unsigned Q1.15, saturated.
module joystick_polar_deadband
  import jpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  raw_x,
  input  logic [7:0]  raw_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] angle,
  output logic [15:0] magnitude,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata
);

  `include "joystick_polar_deadband_macros.svh"

  localparam int LAST = NUM_STAGES - 1;

  logic [14:0] deadband;
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] vld_next;
  jpd_stage_t st [NUM_STAGES];
  jpd_stage_t st_next [NUM_STAGES];
  logic en;

  logic signed [8:0] dx;
  logic signed [8:0] dy;
  logic [8:0] adx;
  logic [8:0] ady;
  logic [17:0] sq;

  assign en = !vld[LAST] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[LAST];
  assign angle = st[LAST].ang;
  assign magnitude = st[LAST].zero ? 16'd0 : (st[LAST].ovf ? 16'hFFFF : st[LAST].q);

  // input decode
  always_comb begin
    dx = $signed({1'b0, raw_x}) - 9'sd128;
    dy = $signed({1'b0, raw_y}) - 9'sd128;
    adx = dx[8] ? 9'(-dx) : dx;
    ady = dy[8] ? 9'(-dy) : dy;
    sq = ({9'b0, adx} * {9'b0, adx}) + ({9'b0, ady} * {9'b0, ady});
  end

  always_comb begin
    vld_next[0] = in_valid;
    st_next[0] = '0;
    st_next[0].upos = dx[8];
    st_next[0].vpos = (dy > 0);
    if (dy == 0) begin
      st_next[0].special = 1'b1;
      st_next[0].sp_acc = dx[8] ? DEG_180 : DEG_360;
    end else if (dx == 0) begin
      st_next[0].special = 1'b1;
      st_next[0].sp_acc = (dy > 0) ? DEG_270 : DEG_90U;
    end
    st_next[0].x = $signed({1'b0, adx, 12'b0});
    st_next[0].y = $signed({1'b0, ady, 12'b0});
    st_next[0].rem = {sq[15:0], 16'b0};
    for (int s = 1; s < NUM_STAGES; s++) begin
      vld_next[s] = vld[s-1];
      if (s <= CORDIC_STEPS) begin
        st_next[s] = jpd_cordic_step(s - 1, st[s-1]);
      end else if (s == SETUP_STAGE) begin
        st_next[s] = jpd_setup(st[s-1], deadband);
      end else if (s < NUM_STAGES - 1) begin
        st_next[s] = jpd_div_step(DIV_STEPS - 1 - (s - SETUP_STAGE - 1), st[s-1]);
      end else begin
        st_next[s] = st[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      deadband <= '0;
    end else begin
      if (en) begin
        vld <= vld_next;
      end
      if (cfg_we) begin
        deadband <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st <= st_next;
    end
  end

  `JPD_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld[0], "request not captured")
  `JPD_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(angle), "result lost in stall")
  `JPD_ASSERT_IMPL(a_angle_range, out_valid, angle <= 15'd23040, "angle beyond full turn")

endmodule
